/* hw/rtl/tcf_pkg.sv */
// shared types, constants and the arctangent table of the tilt filter
package tcf_pkg;

  localparam int TCF_SAMPLE_WIDTH = 16;
  localparam int TCF_ANGLE_WIDTH  = 24;

  localparam int TCF_CORDIC_STEPS = 22;
  localparam int TCF_IDX_W        = $clog2(TCF_CORDIC_STEPS);
  localparam int TCF_ZW           = 26;
  localparam int TCF_TILT_W       = TCF_ZW - 4;

  localparam int TCF_WEIGHT_W     = 17;
  localparam int TCF_PERIOD_W     = 24;
  localparam int TCF_CFG_INDEX_W  = 8;
  localparam int TCF_CFG_DATA_W   = 24;

  localparam logic [TCF_WEIGHT_W-1:0] TCF_WEIGHT_ONE   = 17'd65536;
  localparam logic [TCF_WEIGHT_W-1:0] TCF_WEIGHT_RESET = 17'd64225;
  localparam logic [TCF_PERIOD_W-1:0] TCF_PERIOD_RESET = 24'd16777;

  localparam logic [TCF_CFG_INDEX_W-1:0] REG_BLEND_WEIGHT  = 8'd0;
  localparam logic [TCF_CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 8'd1;

  // plus and minus ninety degrees in 1/65536 degree
  localparam logic signed [TCF_ZW-1:0] TCF_Z_POS90 = 26'sd5898240;
  localparam logic signed [TCF_ZW-1:0] TCF_Z_NEG90 = -26'sd5898240;

  typedef struct packed {
    logic                 load;
    logic                 sq_y;
    logic                 sq_z;
    logic                 sqrt_step;
    logic                 cordic_step;
    logic [TCF_IDX_W-1:0] cordic_idx;
    logic                 roll_save;
    logic                 pitch_init;
    logic                 pitch_save;
    logic                 gyro_mul;
    logic                 gyro_add;
    logic                 blend_mul;
    logic                 blend_done;
  } tcf_cmd_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [TCF_ZW-1:0] tcf_atan(input logic [TCF_IDX_W-1:0] idx);
    case (idx)
      5'd0:    tcf_atan = 26'sd2949120;
      5'd1:    tcf_atan = 26'sd1740967;
      5'd2:    tcf_atan = 26'sd919879;
      5'd3:    tcf_atan = 26'sd466945;
      5'd4:    tcf_atan = 26'sd234379;
      5'd5:    tcf_atan = 26'sd117304;
      5'd6:    tcf_atan = 26'sd58666;
      5'd7:    tcf_atan = 26'sd29335;
      5'd8:    tcf_atan = 26'sd14668;
      5'd9:    tcf_atan = 26'sd7334;
      5'd10:   tcf_atan = 26'sd3667;
      5'd11:   tcf_atan = 26'sd1833;
      5'd12:   tcf_atan = 26'sd917;
      5'd13:   tcf_atan = 26'sd458;
      5'd14:   tcf_atan = 26'sd229;
      5'd15:   tcf_atan = 26'sd115;
      5'd16:   tcf_atan = 26'sd57;
      5'd17:   tcf_atan = 26'sd29;
      5'd18:   tcf_atan = 26'sd14;
      5'd19:   tcf_atan = 26'sd7;
      5'd20:   tcf_atan = 26'sd4;
      5'd21:   tcf_atan = 26'sd2;
      default: tcf_atan = '0;
    endcase
  endfunction

endpackage

/* hw/rtl/tcf_if.sv */
// handshake channels of the tilt filter: samples in, angles out, register writes
interface tcf_sample_if import tcf_pkg::*; #(
  parameter int SAMPLE_WIDTH = TCF_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  logic signed [SAMPLE_WIDTH-1:0] gyro_roll_rate;
  logic signed [SAMPLE_WIDTH-1:0] gyro_pitch_rate;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_roll_rate,
                  gyro_pitch_rate, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_roll_rate,
                gyro_pitch_rate, output ready);
endinterface

interface tcf_angle_if import tcf_pkg::*; #(
  parameter int ANGLE_WIDTH = TCF_ANGLE_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] roll_angle;
  logic signed [ANGLE_WIDTH-1:0] pitch_angle;

  modport source (output valid, roll_angle, pitch_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, output ready);
endinterface

interface tcf_cfg_if import tcf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [TCF_CFG_INDEX_W-1:0] index;
  logic [TCF_CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/tcf_ctrl.sv */
// sequencer of the tilt filter: item handshake, step counters and datapath commands
module tcf_ctrl import tcf_pkg::*; #(
  parameter int SAMPLE_WIDTH = TCF_SAMPLE_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tcf_cmd_t cmd
);

  localparam int CCW = $clog2(TCF_CORDIC_STEPS + 1);
  localparam int SCW = $clog2(SAMPLE_WIDTH + 3);
  localparam logic [CCW-1:0] C_DONE  = CCW'(TCF_CORDIC_STEPS);
  localparam logic [SCW-1:0] S_SQ_Y  = SCW'(0);
  localparam logic [SCW-1:0] S_SQ_Z  = SCW'(1);
  localparam logic [SCW-1:0] S_DONE  = SCW'(SAMPLE_WIDTH + 2);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_TILT  = 8'b0000_0010,
    ST_PINIT = 8'b0000_0100,
    ST_PITCH = 8'b0000_1000,
    ST_GMUL  = 8'b0001_0000,
    ST_GADD  = 8'b0010_0000,
    ST_BMUL  = 8'b0100_0000,
    ST_BLEND = 8'b1000_0000
  } state_t;

  state_t         state, state_next;
  logic [CCW-1:0] ccnt, ccnt_next;
  logic [SCW-1:0] scnt, scnt_next;
  logic           out_valid_next;
  logic           out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    ccnt_next  = ccnt;
    scnt_next  = scnt;
    cmd        = '0;
    cmd.cordic_idx = ccnt[TCF_IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          ccnt_next  = '0;
          scnt_next  = '0;
          state_next = ST_TILT;
        end
      end
      ST_TILT: begin
        // roll vectoring and the root run side by side
        if (ccnt != C_DONE) begin
          cmd.cordic_step = 1'b1;
          ccnt_next = ccnt + 1'b1;
        end
        if (scnt != S_DONE) begin
          cmd.sq_y      = (scnt == S_SQ_Y);
          cmd.sq_z      = (scnt == S_SQ_Z);
          cmd.sqrt_step = (scnt != S_SQ_Y) && (scnt != S_SQ_Z);
          scnt_next = scnt + 1'b1;
        end
        if (ccnt == C_DONE && scnt == S_DONE) begin
          ccnt_next  = '0;
          state_next = ST_PINIT;
        end
      end
      ST_PINIT: begin
        cmd.roll_save  = 1'b1;
        cmd.pitch_init = 1'b1;
        state_next = ST_PITCH;
      end
      ST_PITCH: begin
        if (ccnt != C_DONE) begin
          cmd.cordic_step = 1'b1;
          ccnt_next = ccnt + 1'b1;
        end else begin
          state_next = ST_GMUL;
        end
      end
      ST_GMUL: begin
        cmd.pitch_save = 1'b1;
        cmd.gyro_mul   = 1'b1;
        state_next = ST_GADD;
      end
      ST_GADD: begin
        cmd.gyro_add = 1'b1;
        state_next = ST_BMUL;
      end
      ST_BMUL: begin
        cmd.blend_mul = 1'b1;
        state_next = ST_BLEND;
      end
      ST_BLEND: begin
        if (out_free) begin
          cmd.blend_done = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.blend_done) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ccnt      <= '0;
      scnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ccnt      <= ccnt_next;
      scnt      <= scnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/tcf_datapath.sv */
// datapath of the tilt filter: registers, root, shared vectoring unit and blend
module tcf_datapath import tcf_pkg::*; #(
  parameter int SAMPLE_WIDTH = TCF_SAMPLE_WIDTH,
  parameter int ANGLE_WIDTH  = TCF_ANGLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tcf_cmd_t                       cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_roll_rate,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_pitch_rate,
  input  logic                           cfg_we,
  input  logic [TCF_CFG_INDEX_W-1:0]     cfg_index,
  input  logic [TCF_CFG_DATA_W-1:0]      cfg_data,
  output logic signed [ANGLE_WIDTH-1:0]  roll_angle,
  output logic signed [ANGLE_WIDTH-1:0]  pitch_angle
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int AW   = ANGLE_WIDTH;
  localparam int VW   = SW + 1;
  localparam int CW   = SW + 19;
  localparam int RW   = SW + 3;
  localparam int PW   = SW + 25;
  localparam int GW   = ((AW > SW + 9) ? AW : SW + 9) + 1;
  localparam int MW   = GW + 18;
  localparam int TMW  = TCF_TILT_W + 18;
  localparam int SUMW = ((MW > TMW) ? MW : TMW) + 1;

  logic [TCF_WEIGHT_W-1:0] blend_weight;
  logic [TCF_PERIOD_W-1:0] sample_period;

  logic signed [SW-1:0] ax_r, ay_r, az_r, gr_r, gp_r;

  logic [2*SW-1:0] sq;
  logic [RW-1:0]   rem;
  logic [SW-1:0]   root;

  logic signed [CW-1:0]     cx, cy;
  logic signed [TCF_ZW-1:0] cz;
  logic                     c_zero;

  logic signed [TCF_TILT_W-1:0] tilt_roll, tilt_pitch;
  logic signed [PW-1:0]         pr_roll, pr_pitch;
  logic signed [GW-1:0]         g_roll, g_pitch;
  logic signed [MW-1:0]         m1_roll, m1_pitch;
  logic signed [TMW-1:0]        m2_roll, m2_pitch;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight  <= TCF_WEIGHT_RESET;
      sample_period <= TCF_PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND_WEIGHT:  blend_weight  <= cfg_data[TCF_WEIGHT_W-1:0];
        REG_SAMPLE_PERIOD: sample_period <= cfg_data[TCF_PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // square root of ay^2 + az^2, one result bit a step
  logic signed [2*SW-1:0] sq_y_prod, sq_z_prod;
  logic [RW-1:0]          rem_sh, trial;
  logic                   root_bit;

  assign sq_y_prod = ay_r * ay_r;
  assign sq_z_prod = az_r * az_r;
  assign rem_sh    = {rem[RW-3:0], sq[2*SW-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign root_bit  = (rem_sh >= trial);

  // vectoring unit, loaded with roll operands at item load and pitch operands later
  logic signed [VW-1:0]     init_x, init_y;
  logic signed [CW-1:0]     xs, ys, cx_init, cy_init, dx, dy;
  logic signed [TCF_ZW-1:0] cz_init, z_round;
  logic signed [TCF_TILT_W-1:0] tilt_now;

  always_comb begin
    if (cmd.pitch_init) begin
      init_y = -VW'(ax_r);
      init_x = $signed({1'b0, root});
    end else begin
      init_y = VW'(accel_y);
      init_x = VW'(accel_z);
    end
    xs = CW'(init_x) <<< 16;
    ys = CW'(init_y) <<< 16;
    if (xs[CW-1]) begin
      if (!ys[CW-1]) begin
        cx_init = ys;
        cy_init = -xs;
        cz_init = TCF_Z_POS90;
      end else begin
        cx_init = -ys;
        cy_init = xs;
        cz_init = TCF_Z_NEG90;
      end
    end else begin
      cx_init = xs;
      cy_init = ys;
      cz_init = '0;
    end
  end

  assign dx       = cy >>> cmd.cordic_idx;
  assign dy       = cx >>> cmd.cordic_idx;
  assign z_round  = cz + TCF_ZW'(8);
  assign tilt_now = c_zero ? '0 : TCF_TILT_W'(z_round >>> 4);

  // gyro step and blend
  logic [TCF_WEIGHT_W-1:0]  alpha, beta;
  logic signed [PW-1:0]     step_roll, step_pitch;
  logic signed [SUMW-1:0]   acc_roll, acc_pitch;

  assign alpha      = (blend_weight > TCF_WEIGHT_ONE) ? TCF_WEIGHT_ONE : blend_weight;
  assign beta       = TCF_WEIGHT_ONE - alpha;
  assign step_roll  = (pr_roll + PW'(32768)) >>> 16;
  assign step_pitch = (pr_pitch + PW'(32768)) >>> 16;
  assign acc_roll   = (SUMW'(m1_roll) + SUMW'(m2_roll) + SUMW'(32768)) >>> 16;
  assign acc_pitch  = (SUMW'(m1_pitch) + SUMW'(m2_pitch) + SUMW'(32768)) >>> 16;

  function automatic logic signed [AW-1:0] sat(input logic signed [SUMW-1:0] v);
    logic fits;
    fits = (v[SUMW-1:AW-1] == {(SUMW-AW+1){v[SUMW-1]}});
    if (fits) begin
      sat = v[AW-1:0];
    end else if (v[SUMW-1]) begin
      sat = {1'b1, {(AW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(AW-1){1'b1}}};
    end
  endfunction

  // stored estimates double as the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_angle  <= '0;
      pitch_angle <= '0;
    end else if (cmd.blend_done) begin
      roll_angle  <= sat(acc_roll);
      pitch_angle <= sat(acc_pitch);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= accel_x;
      ay_r <= accel_y;
      az_r <= accel_z;
      gr_r <= gyro_roll_rate;
      gp_r <= gyro_pitch_rate;
    end
    if (cmd.sq_y) begin
      sq   <= sq_y_prod;
      rem  <= '0;
      root <= '0;
    end else if (cmd.sq_z) begin
      sq <= sq + sq_z_prod;
    end else if (cmd.sqrt_step) begin
      sq   <= sq << 2;
      rem  <= root_bit ? (rem_sh - trial) : rem_sh;
      root <= {root[SW-2:0], root_bit};
    end
    if (cmd.load || cmd.pitch_init) begin
      cx     <= cx_init;
      cy     <= cy_init;
      cz     <= cz_init;
      c_zero <= (init_x == '0) && (init_y == '0);
    end else if (cmd.cordic_step) begin
      if (!cy[CW-1]) begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + tcf_atan(cmd.cordic_idx);
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - tcf_atan(cmd.cordic_idx);
      end
    end
    if (cmd.roll_save) begin
      tilt_roll <= tilt_now;
    end
    if (cmd.pitch_save) begin
      tilt_pitch <= tilt_now;
    end
    if (cmd.gyro_mul) begin
      pr_roll  <= gr_r * $signed({1'b0, sample_period});
      pr_pitch <= gp_r * $signed({1'b0, sample_period});
    end
    if (cmd.gyro_add) begin
      g_roll  <= GW'(roll_angle) + GW'(step_roll);
      g_pitch <= GW'(pitch_angle) + GW'(step_pitch);
    end
    if (cmd.blend_mul) begin
      m1_roll  <= $signed({1'b0, alpha}) * g_roll;
      m1_pitch <= $signed({1'b0, alpha}) * g_pitch;
      m2_roll  <= $signed({1'b0, beta}) * tilt_roll;
      m2_pitch <= $signed({1'b0, beta}) * tilt_pitch;
    end
  end

endmodule

/* hw/rtl/tilt_complementary_filter.sv */
// top level of the roll and pitch complementary filter
//
//   channel  dir  payload                                        accepted when
//   sample   in   accel_x, accel_y, accel_z, gyro_roll_rate,     valid && ready
//                 gyro_pitch_rate
//   angle    out  roll_angle, pitch_angle                        valid && ready
//   cfg      in   index, data                                    valid && ready
//
// one item in flight; the input slot is free again only after the item has passed the
// one-step-a-cycle vectoring unit run twice, with the bit-serial root running alongside
// the first pass, and then the gyro and blend steps
// reset restores the register defaults and clears both angle estimates at once
// the result waits in the output register; a stalled output holds the next item
// in its final blend step, configuration writes are always taken
module tilt_complementary_filter import tcf_pkg::*; #(
  parameter int SAMPLE_WIDTH = TCF_SAMPLE_WIDTH,
  parameter int ANGLE_WIDTH  = TCF_ANGLE_WIDTH
) (
  input logic         clk,
  input logic         rst,
  tcf_sample_if.sink  sample,
  tcf_angle_if.source angle,
  tcf_cfg_if.sink     cfg
);

  tcf_cmd_t cmd;

  assign cfg.ready = 1'b1;

  tcf_ctrl #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (angle.valid),
    .out_ready (angle.ready),
    .cmd       (cmd)
  );

  tcf_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .accel_x         (sample.accel_x),
    .accel_y         (sample.accel_y),
    .accel_z         (sample.accel_z),
    .gyro_roll_rate  (sample.gyro_roll_rate),
    .gyro_pitch_rate (sample.gyro_pitch_rate),
    .cfg_we          (cfg.valid && cfg.ready),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .roll_angle      (angle.roll_angle),
    .pitch_angle     (angle.pitch_angle)
  );

endmodule

/* dv/tilt_complementary_filter_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for the tilt filter: directed and random imu items, angles predicted
module tilt_complementary_filter_tb;
  import tcf_pkg::*;

  localparam int     RESET_CYCLES = 7;
  localparam int     LONG_HOLD    = 400;
  localparam int     SETTLE       = 64;
  localparam int     CYCLE_LIMIT  = 1000000;
  localparam int     PHASES       = 10;
  localparam int     PHASE_ITEMS  = 170;
  localparam int     HOLD_PHASE   = 3;
  localparam longint UNITY        = 65536;
  localparam longint RIGHT_ANGLE  = 90 * 65536;
  localparam longint ANGLE_MAX    = (longint'(1) << (TCF_ANGLE_WIDTH - 1)) - 1;
  localparam longint ANGLE_MIN    = -ANGLE_MAX - 1;

  typedef logic signed [TCF_SAMPLE_WIDTH-1:0] sample_word_t;
  typedef logic signed [TCF_ANGLE_WIDTH-1:0]  angle_word_t;
  typedef logic [TCF_CFG_INDEX_W-1:0]         cfg_index_t;
  typedef logic [TCF_CFG_DATA_W-1:0]          cfg_word_t;

  localparam sample_word_t SAMPLE_MIN = {1'b1, {(TCF_SAMPLE_WIDTH-1){1'b0}}};
  localparam sample_word_t SAMPLE_MAX = ~SAMPLE_MIN;
  localparam cfg_index_t   REG_FIRST_UNMAPPED = REG_SAMPLE_PERIOD + 1'b1;
  localparam cfg_index_t   REG_LAST_INDEX = '1;
  localparam cfg_word_t    DATA_ALL_ONES = '1;

  typedef enum {STALL_NONE, STALL_HALF, STALL_SPARSE, STALL_TOGGLE} stall_mode_t;

  typedef struct packed {
    sample_word_t accel_x;
    sample_word_t accel_y;
    sample_word_t accel_z;
    sample_word_t gyro_roll_rate;
    sample_word_t gyro_pitch_rate;
  } imu_item_t;

  typedef struct packed {
    angle_word_t roll_angle;
    angle_word_t pitch_angle;
  } angle_pair_t;

  class angle_tracker;
    longint      roll_est;
    longint      pitch_est;
    longint      weight;
    longint      period;
    angle_pair_t pending_angles[$];
    int          mismatches;

    function new();
      roll_est   = 0;
      pitch_est  = 0;
      weight     = TCF_WEIGHT_RESET;
      period     = TCF_PERIOD_RESET;
      mismatches = 0;
    endfunction

    function void write_register(cfg_index_t index, cfg_word_t data);
      if (index == REG_BLEND_WEIGHT)
        weight = data[TCF_WEIGHT_W-1:0];
      else if (index == REG_SAMPLE_PERIOD)
        period = data[TCF_PERIOD_W-1:0];
    endfunction

    function longint atan_step(int i);
      case (i)
        0:       return 2949120;
        1:       return 1740967;
        2:       return 919879;
        3:       return 466945;
        4:       return 234379;
        5:       return 117304;
        6:       return 58666;
        7:       return 29335;
        8:       return 14668;
        9:       return 7334;
        10:      return 3667;
        11:      return 1833;
        12:      return 917;
        13:      return 458;
        14:      return 229;
        15:      return 115;
        16:      return 57;
        17:      return 29;
        18:      return 14;
        19:      return 7;
        20:      return 4;
        default: return 2;
      endcase
    endfunction

    function longint root(longint unsigned n);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = longint'(1) << 62;
      while (probe > n)
        probe >>= 2;
      while (probe != 0) begin
        if (n >= res + probe) begin
          n -= res + probe;
          res = (res >> 1) + probe;
        end else begin
          res >>= 1;
        end
        probe >>= 2;
      end
      return res;
    endfunction

    // vectoring atan2(y, x) in 1/4096 degree
    function longint tilt_angle(longint y, longint x);
      longint z;
      longint t;
      longint dx;
      longint dy;
      z = 0;
      if (x == 0 && y == 0)
        return 0;
      x = x * 65536;
      y = y * 65536;
      if (x < 0) begin
        if (y >= 0) begin
          t = x;
          x = y;
          y = -t;
          z = RIGHT_ANGLE;
        end else begin
          t = x;
          x = -y;
          y = t;
          z = -RIGHT_ANGLE;
        end
      end
      for (int i = 0; i < TCF_CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += atan_step(i);
        end else begin
          x -= dx;
          y += dy;
          z -= atan_step(i);
        end
      end
      return (z + 8) >>> 4;
    endfunction

    function longint blend(longint old, longint rate, longint tilt);
      longint alpha;
      longint gyro_step;
      longint acc;
      longint v;
      alpha = (weight > UNITY) ? UNITY : weight;
      gyro_step = (rate * period + 32768) >>> 16;
      acc = alpha * (old + gyro_step) + (UNITY - alpha) * tilt + 32768;
      v = acc >>> 16;
      if (v > ANGLE_MAX)
        v = ANGLE_MAX;
      if (v < ANGLE_MIN)
        v = ANGLE_MIN;
      return v;
    endfunction

    function void take_sample(imu_item_t s);
      longint      ax;
      longint      ay;
      longint      az;
      longint      r;
      angle_pair_t a;
      ax = $signed(s.accel_x);
      ay = $signed(s.accel_y);
      az = $signed(s.accel_z);
      r = root(ay * ay + az * az);
      roll_est  = blend(roll_est, $signed(s.gyro_roll_rate), tilt_angle(ay, az));
      pitch_est = blend(pitch_est, $signed(s.gyro_pitch_rate), tilt_angle(-ax, r));
      a.roll_angle  = angle_word_t'(roll_est);
      a.pitch_angle = angle_word_t'(pitch_est);
      pending_angles.push_back(a);
    endfunction

    function void compare_angles(angle_word_t roll, angle_word_t pitch);
      angle_pair_t a;
      if (pending_angles.size() == 0) begin
        $error("angle item with no sample waiting: roll_angle %0d, pitch_angle %0d",
               roll, pitch);
        mismatches++;
        return;
      end
      a = pending_angles.pop_front();
      if (roll !== a.roll_angle) begin
        $error("roll_angle: expected %0d, actual %0d", a.roll_angle, roll);
        mismatches++;
      end
      if (pitch !== a.pitch_angle) begin
        $error("pitch_angle: expected %0d, actual %0d", a.pitch_angle, pitch);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_angles.size();
    endfunction
  endclass

  logic         clk;
  logic         rst;
  angle_tracker tracker = new();
  int           holds_asked = 0;
  int           holds_granted = 0;
  int           hold_left = 0;
  int           mode_left = 0;
  int           cycle_count = 0;
  stall_mode_t  stall_mode = STALL_NONE;

  tcf_sample_if sample_ch ();
  tcf_angle_if  angle_ch ();
  tcf_cfg_if    cfg_ch ();

  tilt_complementary_filter DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .angle  (angle_ch),
    .cfg    (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check accepted items, stall on a pattern of its own
  always @(posedge clk) begin
    if (!rst && angle_ch.valid && angle_ch.ready)
      tracker.compare_angles(angle_ch.roll_angle, angle_ch.pitch_angle);
    if (holds_granted != holds_asked) begin
      holds_granted++;
      hold_left = LONG_HOLD;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 240);
    end else begin
      mode_left--;
    end
    if (rst || hold_left > 0) begin
      if (hold_left > 0)
        hold_left--;
      angle_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_NONE:   angle_ch.ready <= 1'b1;
        STALL_HALF:   angle_ch.ready <= ($urandom_range(0, 1) == 1);
        STALL_SPARSE: angle_ch.ready <= ($urandom_range(0, 3) == 0);
        default:      angle_ch.ready <= ~angle_ch.ready;
      endcase
    end
  end

  function automatic imu_item_t make_sample(int ax, int ay, int az, int gr, int gp);
    imu_item_t s;
    s.accel_x         = sample_word_t'(ax);
    s.accel_y         = sample_word_t'(ay);
    s.accel_z         = sample_word_t'(az);
    s.gyro_roll_rate  = sample_word_t'(gr);
    s.gyro_pitch_rate = sample_word_t'(gp);
    return s;
  endfunction

  function automatic sample_word_t spread(int span);
    int v;
    v = $urandom_range(0, 2 * span);
    return sample_word_t'(v - span);
  endfunction

  function automatic sample_word_t corner_value();
    case ($urandom_range(0, 5))
      0:       return SAMPLE_MIN;
      1:       return sample_word_t'(-1);
      2:       return sample_word_t'(0);
      3:       return sample_word_t'(1);
      4:       return SAMPLE_MAX;
      default: return sample_word_t'($urandom);
    endcase
  endfunction

  function automatic imu_item_t random_sample();
    imu_item_t s;
    int        span;
    int        zeros;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        span = $urandom_range(256, 20000);
        s.accel_x         = spread(span);
        s.accel_y         = spread(span);
        s.accel_z         = spread(span);
        s.gyro_roll_rate  = spread(4000);
        s.gyro_pitch_rate = spread(4000);
      end
      6, 7, 8: begin
        s.accel_x         = sample_word_t'($urandom);
        s.accel_y         = sample_word_t'($urandom);
        s.accel_z         = sample_word_t'($urandom);
        s.gyro_roll_rate  = sample_word_t'($urandom);
        s.gyro_pitch_rate = sample_word_t'($urandom);
        zeros = $urandom_range(0, 7);
        if (zeros[0])
          s.accel_x = '0;
        if (zeros[1])
          s.accel_y = '0;
        if (zeros[2])
          s.accel_z = '0;
      end
      default: begin
        s.accel_x         = corner_value();
        s.accel_y         = corner_value();
        s.accel_z         = corner_value();
        s.gyro_roll_rate  = corner_value();
        s.gyro_pitch_rate = corner_value();
      end
    endcase
    return s;
  endfunction

  function automatic cfg_word_t pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return cfg_word_t'(TCF_WEIGHT_ONE);
      2:       return DATA_ALL_ONES;
      3:       return cfg_word_t'(TCF_WEIGHT_RESET);
      4:       return cfg_word_t'($urandom_range(0, 65536));
      default: return cfg_word_t'($urandom_range(60000, 65536));
    endcase
  endfunction

  function automatic cfg_word_t pick_period();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DATA_ALL_ONES;
      2:       return cfg_word_t'(TCF_PERIOD_RESET);
      3:       return cfg_word_t'($urandom_range(0, 65536));
      default: return cfg_word_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(input imu_item_t s);
    sample_ch.valid           <= 1'b1;
    sample_ch.accel_x         <= s.accel_x;
    sample_ch.accel_y         <= s.accel_y;
    sample_ch.accel_z         <= s.accel_z;
    sample_ch.gyro_roll_rate  <= s.gyro_roll_rate;
    sample_ch.gyro_pitch_rate <= s.gyro_pitch_rate;
    do @(posedge clk); while (!sample_ch.ready);
    tracker.take_sample(s);
  endtask

  task automatic write_register(input cfg_index_t index, input cfg_word_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.write_register(index, data);
  endtask

  task automatic configure(input cfg_word_t weight, input cfg_word_t period, input bit stray);
    write_register(REG_BLEND_WEIGHT, weight);
    write_register(REG_SAMPLE_PERIOD, period);
    if (stray)
      write_register(cfg_index_t'($urandom_range(REG_FIRST_UNMAPPED, REG_LAST_INDEX)),
                     cfg_word_t'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_angles();
    sample_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0)
      @(posedge clk);
  endtask

  task automatic send_random(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        send_sample(random_sample());
        burst--;
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    rst                       = 1'b1;
    sample_ch.valid           = 1'b0;
    sample_ch.accel_x         = '0;
    sample_ch.accel_y         = '0;
    sample_ch.accel_z         = '0;
    sample_ch.gyro_roll_rate  = '0;
    sample_ch.gyro_pitch_rate = '0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = '0;
    cfg_ch.data               = '0;
    angle_ch.ready            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: level, inverted, on the side, axis extremes
    send_sample(make_sample(0, 0, 0, 0, 0));
    send_sample(make_sample(0, 0, 16384, 0, 0));
    send_sample(make_sample(0, 0, -16384, 0, 0));
    send_sample(make_sample(0, 16384, 0, 0, 0));
    send_sample(make_sample(0, -16384, 0, 0, 0));
    send_sample(make_sample(-32768, 0, 0, 32767, -32768));
    send_sample(make_sample(32767, 0, 0, -32768, 32767));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768));
    send_sample(make_sample(-1, -1, -1, -1, -1));
    send_sample(make_sample(1, -32768, -1, 1000, -1000));
    wait_for_angles();

    // accel path only
    configure('0, cfg_word_t'(TCF_PERIOD_RESET), 1'b0);
    send_sample(make_sample(0, 0, -1, 0, 0));
    send_sample(make_sample(0, 0, 0, 0, 0));
    send_sample(make_sample(1234, -20000, -30000, 0, 0));
    send_sample(make_sample(-32768, 32767, -32768, 0, 0));
    wait_for_angles();

    // gyro path only with the longest step: drive both limits
    configure(cfg_word_t'(TCF_WEIGHT_ONE), DATA_ALL_ONES, 1'b0);
    repeat (3) send_sample(make_sample(0, 0, 16384, 32767, 32767));
    repeat (4) send_sample(make_sample(0, 0, 16384, -32768, -32768));
    wait_for_angles();

    // weight above one, plus a write to an unmapped index
    configure(DATA_ALL_ONES, cfg_word_t'(TCF_PERIOD_RESET), 1'b1);
    send_sample(make_sample(100, 200, 300, -32768, 32767));
    send_sample(make_sample(-100, -200, -300, 32767, -32768));
    wait_for_angles();

    configure(cfg_word_t'(TCF_WEIGHT_RESET), '0, 1'b0);
    send_sample(make_sample(500, -500, 16000, 32767, -32768));
    wait_for_angles();

    for (int phase = 0; phase < PHASES; phase++) begin
      configure(pick_weight(), pick_period(), $urandom_range(0, 2) == 0);
      if (phase == HOLD_PHASE)
        holds_asked <= holds_asked + 1;
      send_random(PHASE_ITEMS);
      wait_for_angles();
    end

    repeat (SETTLE) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
